// ----- rtl/core/res_pkg.sv -----
// ----------------------------------------------------------------------------
// res_pkg
// Shared types, sizes and field offsets for the readout error sampler.
// ----------------------------------------------------------------------------
package res_pkg;

  localparam int unsigned QUBITS    = 16;
  localparam int unsigned FACTORS   = 16;
  localparam int unsigned SPAN_MAX  = 4;
  localparam int unsigned PROB_FRAC = 16;

  localparam int unsigned POS_W    = $clog2(QUBITS);
  localparam int unsigned FAC_W    = $clog2(FACTORS);
  localparam int unsigned DIM      = 1 << SPAN_MAX;
  localparam int unsigned LOC_W    = SPAN_MAX;
  localparam int unsigned SPAN_W   = 3;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned PROB_W   = PROB_FRAC + 1;
  localparam int unsigned DRAW_W   = PROB_FRAC;
  localparam int unsigned ACC_W    = PROB_W + SPAN_MAX;
  localparam int unsigned MAT_DEPTH = FACTORS * DIM * DIM;
  localparam int unsigned MAT_AW   = $clog2(MAT_DEPTH);

  // stream packing, lowest bit first
  localparam int unsigned TDATA_W  = 80;
  localparam int unsigned TUSER_W  = 2;
  localparam int unsigned OUT_W    = 16;
  localparam int unsigned OFS_FSEL = 0;
  localparam int unsigned OFS_SPAN = 4;
  localparam int unsigned OFS_POSA = 7;
  localparam int unsigned OFS_ROW  = 23;
  localparam int unsigned OFS_COL  = 27;
  localparam int unsigned OFS_PROB = 31;
  localparam int unsigned OFS_PREP = 48;
  localparam int unsigned OFS_DRAW = 64;

  typedef enum logic [1:0] {
    OP_FACTOR = 2'd0,
    OP_MATRIX = 2'd1,
    OP_START  = 2'd2,
    OP_DRAW   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GATHER,
    ST_WALK,
    ST_SCATTER,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic accept;
    logic gather;
    logic walk;
    logic scatter;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_draw;
    logic walk_done;
    logic is_last;
  } stat_t;

endpackage

// ----- rtl/core/res_ram.sv -----
// ----------------------------------------------------------------------------
// res_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module res_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/res_ctrl.sv -----
// ----------------------------------------------------------------------------
// res_ctrl
// Sequencer: accepts requests, runs gather / column walk / scatter per draw.
// ----------------------------------------------------------------------------
module res_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output res_pkg::cmd_t  cmd_o,
  input  res_pkg::stat_t stat_i
);
  import res_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && stat_i.is_draw) begin
          state_d = ST_GATHER;
        end
      end
      ST_GATHER: begin
        cmd_o.gather = 1'b1;
        state_d      = ST_WALK;
      end
      ST_WALK: begin
        cmd_o.walk = 1'b1;
        if (stat_i.walk_done) begin
          state_d = ST_SCATTER;
        end
      end
      ST_SCATTER: begin
        cmd_o.scatter = 1'b1;
        state_d       = stat_i.is_last ? ST_DONE : ST_IDLE;
      end
      ST_DONE: begin
        // hold until the output register can take the new result
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/core/res_dp.sv -----
// ----------------------------------------------------------------------------
// res_dp
// Datapath: factor tables, matrix RAM, shot bits, cumulative walk, output.
// ----------------------------------------------------------------------------
module res_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [res_pkg::TDATA_W-1:0]  in_data_i,
  input  logic [res_pkg::TUSER_W-1:0]  in_user_i,
  input  logic                         cfg_we_i,
  input  logic [res_pkg::CNT_W-1:0]    cfg_data_i,
  input  res_pkg::cmd_t                cmd_i,
  output res_pkg::stat_t               stat_o,
  output logic [res_pkg::OUT_W-1:0]    out_data_o
);
  import res_pkg::*;

  // request fields
  op_e                      op;
  logic [FAC_W-1:0]         in_fsel;
  logic [SPAN_W-1:0]        in_span;
  logic [SPAN_MAX*POS_W-1:0] in_pos;
  logic [LOC_W-1:0]         in_row, in_col;
  logic [PROB_W-1:0]        in_prob;
  logic [QUBITS-1:0]        in_prep;
  logic [DRAW_W-1:0]        in_draw;

  assign op      = op_e'(in_user_i);
  assign in_fsel = in_data_i[OFS_FSEL +: FAC_W];
  assign in_span = in_data_i[OFS_SPAN +: SPAN_W];
  assign in_pos  = in_data_i[OFS_POSA +: SPAN_MAX*POS_W];
  assign in_row  = in_data_i[OFS_ROW +: LOC_W];
  assign in_col  = in_data_i[OFS_COL +: LOC_W];
  assign in_prob = in_data_i[OFS_PROB +: PROB_W];
  assign in_prep = in_data_i[OFS_PREP +: QUBITS];
  assign in_draw = in_data_i[OFS_DRAW +: DRAW_W];

  // state
  logic [SPAN_W-1:0]         span_tab_q [FACTORS];
  logic [SPAN_MAX*POS_W-1:0] pos_tab_q  [FACTORS];
  logic [QUBITS-1:0]         shot_q, shot_d;
  logic [FAC_W-1:0]          next_q, next_d;
  logic [CNT_W-1:0]          count_q;
  logic [FAC_W-1:0]          fac_q;
  logic [DRAW_W-1:0]         draw_q;
  logic [LOC_W-1:0]          row_q, row_d;
  logic [SPAN_W-1:0]         span_q, span_d;
  logic [LOC_W-1:0]          last_col_q, last_col_d;
  logic [LOC_W-1:0]          col_q;
  logic [ACC_W-1:0]          acc_q, acc_sum;
  logic [OUT_W-1:0]          out_q;
  logic [PROB_W-1:0]         rdata;
  logic [MAT_AW-1:0]         raddr, waddr;
  logic                      hit;
  logic [CNT_W-1:0]          cnt_eff;
  logic [SPAN_W-1:0]         span_raw;
  logic [SPAN_MAX*POS_W-1:0] pos_cur;

  assign span_raw = span_tab_q[fac_q];
  assign pos_cur  = pos_tab_q[fac_q];

  // gather: clamp span, build row index from the shot bits
  always_comb begin
    span_d = span_raw;
    if (span_raw == '0) begin
      span_d = SPAN_W'(1);
    end else if (span_raw > SPAN_W'(SPAN_MAX)) begin
      span_d = SPAN_W'(SPAN_MAX);
    end
    last_col_d = LOC_W'((DIM'(1) << span_d) - 1);
    row_d = '0;
    for (int k = 0; k < SPAN_MAX; k++) begin
      if (SPAN_W'(k) < span_d) begin
        row_d[k] = shot_q[pos_cur[k*POS_W +: POS_W]];
      end
    end
  end

  // walk: one column per cycle
  assign acc_sum = acc_q + ACC_W'(rdata);
  assign hit     = (ACC_W'(draw_q) < acc_sum) || (col_q == last_col_q);

  assign raddr = cmd_i.gather ? {fac_q, row_d, LOC_W'(0)}
                              : {fac_q, row_q, LOC_W'(col_q + LOC_W'(1))};
  assign waddr = {in_fsel, in_row, in_col};

  res_ram #(
    .WIDTH (PROB_W),
    .DEPTH (MAT_DEPTH)
  ) u_mat (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept && (op == OP_MATRIX)),
    .waddr_i (waddr),
    .wdata_i (in_prob),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // factor count clamp and end-of-shot test
  always_comb begin
    cnt_eff = count_q;
    if (count_q == '0) begin
      cnt_eff = CNT_W'(1);
    end else if (count_q > CNT_W'(FACTORS)) begin
      cnt_eff = CNT_W'(FACTORS);
    end
  end

  assign stat_o.is_last   = (CNT_W'(next_q) + CNT_W'(1)) >= cnt_eff;
  assign stat_o.walk_done = hit;
  assign stat_o.is_draw   = (op == OP_DRAW);

  // scatter and shot-bit update; later local bits win
  always_comb begin
    shot_d = shot_q;
    next_d = next_q;
    if (cmd_i.accept && (op == OP_START)) begin
      shot_d = in_prep;
      next_d = '0;
    end else if (cmd_i.scatter) begin
      for (int k = 0; k < SPAN_MAX; k++) begin
        if (SPAN_W'(k) < span_q) begin
          shot_d[pos_cur[k*POS_W +: POS_W]] = col_q[k];
        end
      end
      next_d = stat_o.is_last ? '0 : FAC_W'(next_q + FAC_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shot_q  <= '0;
      next_q  <= '0;
      count_q <= CNT_W'(1);
    end else begin
      shot_q <= shot_d;
      next_q <= next_d;
      if (cfg_we_i) begin
        count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && (op == OP_FACTOR)) begin
      span_tab_q[in_fsel] <= in_span;
      pos_tab_q[in_fsel]  <= in_pos;
    end
    if (cmd_i.accept && (op == OP_DRAW)) begin
      draw_q <= in_draw;
      fac_q  <= next_q;
    end
    if (cmd_i.gather) begin
      row_q      <= row_d;
      span_q     <= span_d;
      last_col_q <= last_col_d;
      col_q      <= '0;
      acc_q      <= '0;
    end else if (cmd_i.walk && !hit) begin
      col_q <= LOC_W'(col_q + LOC_W'(1));
      acc_q <= acc_sum;
    end
    if (cmd_i.load_out) begin
      out_q <= shot_q;
    end
  end

  assign out_data_o = out_q;

endmodule

// ----- rtl/core/readout_error_sampler_top.sv -----
// ----------------------------------------------------------------------------
// readout_error_sampler_top
// Injects readout errors into a measured bit vector by inverse-CDF sampling.
// ----------------------------------------------------------------------------
// Timing: table writes and shot start are taken in IDLE. A draw runs gather,
//   a walk of C columns, C = 1..16, one matrix RAM read per column, and
//   scatter; a draw ending a shot then waits in DONE to load the output register.
// Throughput: one request at a time; next request taken when the draw ends.
// Reset: async active low; shot bits and factor index clear, factor_count
//   returns to 1. Factor tables and matrix RAM are undefined until written.
module readout_error_sampler_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request stream
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // tdata, from bit 0: factor_sel[4] span[3] pos_a[4] pos_b[4] pos_c[4]
  //   pos_d[4] row_sel[4] col_sel[4] prob[17] prepared_bits[16] uniform[16]
  input  logic [res_pkg::TDATA_W-1:0]  s_axis_tdata_i,
  // tuser: op[2]
  input  logic [res_pkg::TUSER_W-1:0]  s_axis_tuser_i,
  // result stream
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // tdata: noisy_bits[16]
  output logic [res_pkg::OUT_W-1:0]    m_axis_tdata_o,
  // factor_count register write
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [res_pkg::CNT_W-1:0]    cfg_data_i
);
  import res_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Register writes must only be issued while idle; the block does not enforce this and always takes them.
  assign cfg_ready_o = 1'b1;

  // Sequencer: owns the request and result handshakes and the output valid flag.
  res_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // Datapath: tables, matrix RAM, cumulative walk and result register.
  res_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (s_axis_tdata_i),
    .in_user_i  (s_axis_tuser_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (m_axis_tdata_o)
  );

endmodule

// ----- rtl/core/res_chk.sv -----
// ----------------------------------------------------------------------------
// res_chk
// Port-level checks for the readout error sampler, bound to the top level.
// ----------------------------------------------------------------------------
module res_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid_i,
  input logic                        s_axis_tready_o,
  input logic [res_pkg::TUSER_W-1:0] s_axis_tuser_i,
  input logic                        m_axis_tvalid_o,
  input logic                        m_axis_tready_i,
  input logic [res_pkg::OUT_W-1:0]   m_axis_tdata_o,
  input logic                        cfg_ready_o
);
  import res_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // a table write or shot start leaves the input ready in the cycle after it
  a_short_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i != OP_DRAW) |=> s_axis_tready_o)
    else $error("non-draw request did not free the input");

  // a draw keeps the input busy while it runs
  a_draw_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == OP_DRAW) |=> !s_axis_tready_o)
    else $error("draw did not hold off the next request");

  // a new result only appears at the end of a draw
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> !$past(s_axis_tready_o) && cfg_ready_o)
    else $error("result appeared outside a draw");

endmodule

bind readout_error_sampler_top res_chk u_res_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .cfg_ready_o     (cfg_ready_o)
);

// ----- verif/readout_error_sampler_top_test.sv -----
// ----------------------------------------------------------------------------
// readout_error_sampler_top_test
// Self-checking bench for the readout error sampler. Table, shot and draw
// requests go in on the request stream. Each accepted request runs through a
// local model of tables, shot bits and factor walk. Noisy bits that come out
// are compared in order against that model or a directed draw's given bits.
// A directed table comes first, then random traffic under four idling schemes.
// ----------------------------------------------------------------------------
module readout_error_sampler_top_test;
  import res_pkg::*;

  localparam int unsigned RUN_LIMIT    = 4 * 1_500_000;
  localparam int unsigned DRAIN_CYCLES = 32;
  localparam int unsigned PHASE_ITEMS  = 125;

  // request fields, packed exactly like tdata (factor_sel in the low bits)
  typedef struct packed {
    logic [15:0]     draw;
    logic [15:0]     prep;
    logic [16:0]     prob;
    logic [3:0]      col;
    logic [3:0]      row;
    logic [15:0]     pos;    // pos_d .. pos_a, pos_a lowest
    logic [2:0]      span;
    logic [3:0]      fsel;
  } req_fields_t;

  typedef struct packed {
    op_e             op;
    req_fields_t     f;
  } req_t;

  typedef struct packed {
    logic            is_cfg;
    logic [CNT_W-1:0] cfg_val;
    req_t            req;
    logic            typed;
    logic [15:0]     noisy;
  } step_t;

  logic                 clk_i;
  logic                 rst_ni          = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [TDATA_W-1:0]   s_axis_tdata_i  = '0;
  logic [TUSER_W-1:0]   s_axis_tuser_i  = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [OUT_W-1:0]     m_axis_tdata_o;
  logic                 cfg_valid_i     = 1'b0;
  logic                 cfg_ready_o;
  logic [CNT_W-1:0]     cfg_data_i      = '0;

  // model state
  logic [2:0]       fac_span [FACTORS];
  logic [15:0]      fac_pos  [FACTORS];
  logic [16:0]      prob_mem [MAT_DEPTH];
  bit               desc_ok  [FACTORS];
  bit               cell_ok  [MAT_DEPTH];
  logic [15:0]      shot_now   = '0;
  logic [4:0]       fac_next   = '0;
  logic [CNT_W-1:0] fac_count  = 5'd1;

  logic [15:0]      noisy_due [$];
  step_t            plan [$];

  int               tx_idle_pct  = 0;
  int               rx_stall_pct = 0;
  int               rx_hold      = 0;
  int unsigned      fault_count  = 0;
  int unsigned      req_count    = 0;
  int unsigned      shot_count   = 0;
  int unsigned      draw_count   = 0;
  int unsigned      result_count = 0;

  readout_error_sampler_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #(RUN_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int eff_span(input logic [2:0] s);
    if (s == 3'd0) return 1;
    if (s > SPAN_MAX) return SPAN_MAX;
    return int'(s);
  endfunction

  // local outcome index built from the factor's qubit positions
  function automatic logic [3:0] gather_row(input logic [3:0] f);
    logic [3:0] idx;
    int         k;
    idx = '0;
    for (k = 0; k < eff_span(fac_span[f]); k++)
      idx[k] = shot_now[fac_pos[f][4*k +: 4]];
    return idx;
  endfunction

  // applies one accepted request; returns 1 when it ends a shot
  function automatic bit predict_readout(input req_t r, output logic [15:0] noisy);
    logic [3:0]  f, row, col;
    logic [20:0] acc;
    int          sp, cnt, c, k;
    bit          found, done;
    noisy = '0;
    done  = 1'b0;
    f     = r.f.fsel;
    case (r.op)
      OP_FACTOR: begin
        fac_span[f] = r.f.span;
        fac_pos[f]  = r.f.pos;
        desc_ok[f]  = 1'b1;
      end
      OP_MATRIX: begin
        prob_mem[{f, r.f.row, r.f.col}] = r.f.prob;
        cell_ok[{f, r.f.row, r.f.col}]  = 1'b1;
      end
      OP_START: begin
        shot_now = r.f.prep;
        fac_next = '0;
      end
      default: begin
        cnt = (fac_count == 0) ? 1 : ((fac_count > FACTORS) ? FACTORS : int'(fac_count));
        f   = fac_next[3:0];
        sp  = eff_span(fac_span[f]);
        row = gather_row(f);
        col = 4'((1 << sp) - 1);
        acc = '0;
        found = 1'b0;
        // inverse-CDF walk; falls through to the last column
        for (c = 0; c < (1 << sp); c++) begin
          if (!found) begin
            acc = acc + 21'(prob_mem[{f, row, 4'(c)}]);
            if (21'(r.f.draw) < acc) begin
              col   = 4'(c);
              found = 1'b1;
            end
          end
        end
        // scatter, higher local bit wins on repeated positions
        for (k = 0; k < sp; k++)
          shot_now[fac_pos[f][4*k +: 4]] = col[k];
        fac_next = fac_next + 5'd1;
        if (fac_next >= cnt) begin
          fac_next = '0;
          noisy    = shot_now;
          done     = 1'b1;
        end
      end
    endcase
    return done;
  endfunction

  function automatic req_t junk_request();
    req_t        r;
    logic [95:0] raw;
    raw  = {$urandom, $urandom, $urandom};
    r.f  = raw[TDATA_W-1:0];
    r.op = OP_DRAW;
    return r;
  endfunction

  function automatic logic [2:0] pick_span();
    int sel;
    sel = $urandom_range(99);
    if (sel < 45) return 3'd1;
    if (sel < 75) return 3'd2;
    if (sel < 85) return 3'd3;
    if (sel < 92) return 3'd4;
    return 3'($urandom_range(0, 7));
  endfunction

  function automatic logic [16:0] pick_prob();
    int sel;
    sel = $urandom_range(99);
    if (sel < 5) return 17'h10000;
    if (sel < 15) return 17'($urandom_range(0, 131071));
    return 17'($urandom_range(0, 40000));
  endfunction

  function automatic req_t random_request();
    req_t r;
    int   sel;
    r   = junk_request();
    sel = $urandom_range(99);
    if (sel < 15) begin
      r.op     = OP_FACTOR;
      r.f.span = pick_span();
    end else if (sel < 30) begin
      r.op     = OP_MATRIX;
      r.f.prob = pick_prob();
    end else if (sel < 45) begin
      r.op = OP_START;
    end else begin
      r.op = OP_DRAW;
      if ($urandom_range(9) == 0) r.f.draw = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    end
    return r;
  endfunction

  // directed table builders
  function automatic void add_factor(input logic [3:0] f, input logic [2:0] sp,
                                     input logic [15:0] pos);
    step_t s;
    s          = '0;
    s.req      = junk_request();
    s.req.op   = OP_FACTOR;
    s.req.f.fsel = f;
    s.req.f.span = sp;
    s.req.f.pos  = pos;
    plan.insert(plan.size(), s);
  endfunction

  function automatic void add_matrix(input logic [3:0] f, input logic [3:0] row,
                                     input logic [3:0] col, input logic [16:0] prob);
    step_t s;
    s            = '0;
    s.req        = junk_request();
    s.req.op     = OP_MATRIX;
    s.req.f.fsel = f;
    s.req.f.row  = row;
    s.req.f.col  = col;
    s.req.f.prob = prob;
    plan.insert(plan.size(), s);
  endfunction

  function automatic void add_start(input logic [15:0] bits);
    step_t s;
    s            = '0;
    s.req        = junk_request();
    s.req.op     = OP_START;
    s.req.f.prep = bits;
    plan.insert(plan.size(), s);
  endfunction

  function automatic void add_draw(input logic [15:0] u, input logic typed,
                                   input logic [15:0] noisy);
    step_t s;
    s            = '0;
    s.req        = junk_request();
    s.req.op     = OP_DRAW;
    s.req.f.draw = u;
    s.typed      = typed;
    s.noisy      = noisy;
    plan.insert(plan.size(), s);
  endfunction

  function automatic void add_cfg(input logic [CNT_W-1:0] v);
    step_t s;
    s         = '0;
    s.is_cfg  = 1'b1;
    s.cfg_val = v;
    plan.insert(plan.size(), s);
  endfunction

  // one request on the stream; the model sees it at the accepting edge
  task automatic send_request(input req_t r, input logic typed, input logic [15:0] typed_noisy);
    logic [15:0] noisy;
    while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= r.f;
    s_axis_tuser_i  <= r.op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    req_count++;
    if (r.op == OP_START) shot_count++;
    if (r.op == OP_DRAW) draw_count++;
    if (predict_readout(r, noisy)) begin
      noisy_due.insert(noisy_due.size(), typed ? typed_noisy : noisy);
    end
  endtask

  // fill in whatever the next draw will read that has not been written yet
  task automatic prime_draw();
    req_t       r;
    logic [3:0] f, row;
    int         c;
    f = fac_next[3:0];
    if (!desc_ok[f]) begin
      r        = junk_request();
      r.op     = OP_FACTOR;
      r.f.fsel = f;
      r.f.span = pick_span();
      send_request(r, 1'b0, '0);
    end
    row = gather_row(f);
    for (c = 0; c < (1 << eff_span(fac_span[f])); c++) begin
      if (!cell_ok[{f, row, 4'(c)}]) begin
        r        = junk_request();
        r.op     = OP_MATRIX;
        r.f.fsel = f;
        r.f.row  = row;
        r.f.col  = 4'(c);
        r.f.prob = pick_prob();
        send_request(r, 1'b0, '0);
      end
    end
  endtask

  // stop sending, wait for every pending result and let the block go idle
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (noisy_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_factor_count(input logic [CNT_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    fac_count = v;
    cfg_valid_i <= 1'b0;
  endtask

  // result side: check on handshake, then pick next tready
  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      result_count++;
      if (noisy_due.size() == 0) begin
        $error("noisy_bits: no result expected, got %h", m_axis_tdata_o);
        fault_count++;
      end else if (m_axis_tdata_o !== noisy_due[0]) begin
        $error("noisy_bits: expected %h, actual %h", noisy_due[0], m_axis_tdata_o);
        fault_count++;
        void'(noisy_due.pop_front());
      end else begin
        void'(noisy_due.pop_front());
      end
    end
    if (rx_hold > 0) begin
      m_axis_tready_i <= 1'b0;
      rx_hold--;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  initial begin
    int               i, ph;
    int unsigned      phase_end;
    int               tx_sched [4];
    int               rx_sched [4];
    logic [CNT_W-1:0] cnt_sched [4];
    req_t             r;

    tx_sched  = '{0, 58, 0, 29};
    rx_sched  = '{0, 0, 58, 29};
    cnt_sched = '{5'd3, 5'd0, 5'd31, 5'd5};

    // flip matrix on qubit 0; draw before any shot works on zero bits
    add_factor(4'd0, 3'd1, 16'hFFF0);
    add_matrix(4'd0, 4'd0, 4'd0, 17'd0);
    add_matrix(4'd0, 4'd0, 4'd1, 17'h10000);
    add_matrix(4'd0, 4'd1, 4'd0, 17'h10000);
    add_matrix(4'd0, 4'd1, 4'd1, 17'd0);
    add_draw(16'h0000, 1'b1, 16'h0001);
    add_start(16'hFFFF);
    add_draw(16'hFFFF, 1'b1, 16'hFFFE);
    add_draw(16'h0000, 1'b1, 16'hFFFF);          // next pass on the noisy bits
    // span 0 acts as 1; row 0 sums to 2 so a large draw takes the last column
    add_factor(4'd1, 3'd0, 16'h000F);
    add_matrix(4'd1, 4'd0, 4'd0, 17'd1);
    add_matrix(4'd1, 4'd0, 4'd1, 17'd1);
    add_matrix(4'd1, 4'd1, 4'd0, 17'h1FFFF);
    add_matrix(4'd1, 4'd1, 4'd1, 17'd0);
    add_cfg(5'd2);
    add_start(16'h0000);
    add_draw(16'h0000, 1'b0, '0);
    add_draw(16'hFFFF, 1'b1, 16'h8001);
    add_draw(16'h0000, 1'b0, '0);
    add_draw(16'hFFFF, 1'b1, 16'h0000);
    // span above max, repeated positions; then count lowered mid-shot
    add_factor(4'd2, 3'd7, 16'hC933);
    add_cfg(5'd16);
    add_start(16'hA5C3);
    repeat (4) add_draw(16'($urandom), 1'b0, '0);
    add_cfg(5'd0);
    add_draw(16'($urandom), 1'b0, '0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[j]) begin
      if (plan[j].is_cfg) begin
        settle();
        write_factor_count(plan[j].cfg_val);
      end else begin
        if (plan[j].req.op == OP_DRAW) prime_draw();
        send_request(plan[j].req, plan[j].typed, plan[j].noisy);
      end
    end

    for (ph = 0; ph < 4; ph++) begin
      settle();
      tx_idle_pct  = tx_sched[ph];
      rx_stall_pct = rx_sched[ph];
      write_factor_count(cnt_sched[ph]);
      if (ph == 2) rx_hold = 400;                // long back-pressure stretch
      // table fills sent ahead of a draw count toward the phase budget
      phase_end = req_count + PHASE_ITEMS;
      i = 0;
      while (req_count < phase_end) begin
        if (ph == 3 && i > 0 && i % 40 == 0) begin
          settle();
          write_factor_count(5'($urandom_range(1, 6)));
        end
        r = random_request();
        if (r.op == OP_DRAW) prime_draw();
        send_request(r, 1'b0, '0);
        i++;
      end
    end
    settle();

    $display("Run covered %0d requests: %0d shots started, %0d draws, %0d noisy results",
             req_count, shot_count, draw_count, result_count);
    $display("Idling: none, sender only, receiver only with long hold-off, both; counts 0..31");
    if (fault_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
